// ===== hdl/gthm_pkg.sv =====
// ----------------------------------------------------------------------------
// gthm_pkg: shared definitions for the grouped tag hash map
// Types, codes and default sizes used by every module of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package gthm_pkg;

  // Default sizes for the top level parameters.
  localparam int DEF_GROUP_SLOTS = 16;
  localparam int DEF_MAX_GROUPS  = 32;
  localparam int DEF_VALUE_WIDTH = 32;

  // Fixed field widths.
  localparam int HASH_W     = 64;
  localparam int NODE_W     = 32;
  localparam int META_W     = 8;
  localparam int LANE_W_MAX = 6;   // enough for up to 64 lanes per group
  localparam int GCL_W      = 3;
  localparam int APB_AW     = 2;
  localparam int APB_DW     = 32;

  // Slot metadata encodings.
  localparam logic [META_W-1:0] META_EMPTY    = 8'h01;
  localparam logic [META_W-1:0] META_DEAD     = 8'h02;
  localparam logic [META_W-1:0] META_TAG_MASK = 8'hFC;

  // Request commands.
  localparam logic CMD_FIND = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_DUP      = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  // Register map (byte addresses).
  localparam logic [APB_AW-1:0] REG_ADDR_GROUP_COUNT_LOG2 = 2'd0;
  localparam logic [GCL_W-1:0]  GCL_RESET                 = 3'd5;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_RESULT
  } gthm_state_t;

  // Outcome of comparing one group row against the request.
  typedef struct packed {
    logic                  hit;
    logic                  has_empty;
    logic                  has_dead;
    logic [LANE_W_MAX-1:0] hit_lane;
    logic [LANE_W_MAX-1:0] empty_lane;
    logic [LANE_W_MAX-1:0] dead_lane;
  } probe_res_t;

  // Slot memory controls from the sequencer.
  typedef struct packed {
    logic                  rd_en;
    logic                  clr_en;
    logic                  wr_en;
    logic [LANE_W_MAX-1:0] wr_lane;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/gthm_cfg.sv =====
// ----------------------------------------------------------------------------
// gthm_cfg: configuration register
// Holds the group count exponent and derives the group mask and count in use.
// ----------------------------------------------------------------------------
`default_nettype none

module gthm_cfg #(
  parameter int MAX_GROUPS = gthm_pkg::DEF_MAX_GROUPS,
  parameter int GW         = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gthm_pkg::APB_AW-1:0]   paddr,
  input  logic [gthm_pkg::APB_DW-1:0]   pwdata,
  output logic [gthm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [GW-1:0]                 grp_mask,
  output logic [GW:0]                   grp_count
);
  import gthm_pkg::*;

  // Largest exponent whose group count still fits in the table.
  localparam int LG_MAX = $clog2(MAX_GROUPS + 1) - 1;
  // The same limit, but never above what the register can hold.
  localparam int LG_TOP = (LG_MAX < (1 << GCL_W)) ? LG_MAX : (1 << GCL_W) - 1;

  logic [GCL_W-1:0] gcl_r;
  logic [GCL_W-1:0] gcl_nxt;
  logic [GCL_W-1:0] lg_eff;
  logic             wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr == REG_ADDR_GROUP_COUNT_LOG2);

  // Register write.
  always_comb begin
    gcl_nxt = gcl_r;
    if (wr_hit) begin
      gcl_nxt = pwdata[GCL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcl_r <= GCL_RESET;
    end else begin
      gcl_r <= gcl_nxt;
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (paddr == REG_ADDR_GROUP_COUNT_LOG2) begin
      prdata = APB_DW'(gcl_r);
    end
  end

  // Saturate the exponent so the group count never exceeds the table.
  assign lg_eff    = (gcl_r > GCL_W'(LG_TOP)) ? GCL_W'(LG_TOP) : gcl_r;
  assign grp_count = (GW + 1)'(1) << lg_eff;
  assign grp_mask  = GW'(grp_count - (GW + 1)'(1));

endmodule

`default_nettype wire

// ===== hdl/gthm_slot_mem.sv =====
// ----------------------------------------------------------------------------
// gthm_slot_mem: slot storage
// One memory per lane for metadata, key hash and value, all addressed by
// group, so a whole group row is read at once.
// ----------------------------------------------------------------------------
`default_nettype none

module gthm_slot_mem #(
  parameter int GROUP_SLOTS = gthm_pkg::DEF_GROUP_SLOTS,
  parameter int MAX_GROUPS  = gthm_pkg::DEF_MAX_GROUPS,
  parameter int VALUE_WIDTH = gthm_pkg::DEF_VALUE_WIDTH,
  parameter int GW          = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1
) (
  input  logic                        clk,
  input  gthm_pkg::mem_ctl_t          ctl,
  input  logic [GW-1:0]               grp,
  input  logic [gthm_pkg::HASH_W-1:0] wr_hash,
  input  logic [VALUE_WIDTH-1:0]      wr_value,
  output logic [gthm_pkg::META_W-1:0] meta_row  [GROUP_SLOTS],
  output logic [gthm_pkg::HASH_W-1:0] hash_row  [GROUP_SLOTS],
  output logic [VALUE_WIDTH-1:0]      value_row [GROUP_SLOTS]
);
  import gthm_pkg::*;

  logic [META_W-1:0] meta_wdata;

  // Clearing writes the empty marker; an insert writes the key tag.
  assign meta_wdata = ctl.clr_en ? META_EMPTY : (wr_hash[META_W-1:0] & META_TAG_MASK);

  for (genvar l = 0; l < GROUP_SLOTS; l++) begin : g_lane
    logic [META_W-1:0]      meta_mem [MAX_GROUPS];
    logic [HASH_W-1:0]      hash_mem [MAX_GROUPS];
    logic [VALUE_WIDTH-1:0] val_mem  [MAX_GROUPS];
    logic                   lane_we;

    assign lane_we = ctl.wr_en && (ctl.wr_lane == LANE_W_MAX'(l));

    // Lane write port and registered row read.
    always_ff @(posedge clk) begin
      if (ctl.clr_en || lane_we) begin
        meta_mem[grp] <= meta_wdata;
      end
      if (lane_we) begin
        hash_mem[grp] <= wr_hash;
        val_mem[grp]  <= wr_value;
      end
      if (ctl.rd_en) begin
        meta_row[l]  <= meta_mem[grp];
        hash_row[l]  <= hash_mem[grp];
        value_row[l] <= val_mem[grp];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gthm_group_probe.sv =====
// ----------------------------------------------------------------------------
// gthm_group_probe: group compare unit
// Compares every lane of one group row with the request in parallel and
// picks the first matching, first empty and first dead lane.
// ----------------------------------------------------------------------------
`default_nettype none

module gthm_group_probe #(
  parameter int GROUP_SLOTS = gthm_pkg::DEF_GROUP_SLOTS
) (
  input  logic [gthm_pkg::META_W-1:0] meta_row [GROUP_SLOTS],
  input  logic [gthm_pkg::HASH_W-1:0] hash_row [GROUP_SLOTS],
  input  logic [gthm_pkg::HASH_W-1:0] key_hash,
  output gthm_pkg::probe_res_t        res
);
  import gthm_pkg::*;

  logic [META_W-1:0] tag;

  assign tag = key_hash[META_W-1:0] & META_TAG_MASK;

  // Scan from the top lane down so the lowest lane wins each pick.
  always_comb begin
    res = '0;
    for (int l = GROUP_SLOTS - 1; l >= 0; l--) begin
      if ((meta_row[l] == tag) && (hash_row[l] == key_hash)) begin
        res.hit      = 1'b1;
        res.hit_lane = LANE_W_MAX'(l);
      end
      if (meta_row[l] == META_EMPTY) begin
        res.has_empty  = 1'b1;
        res.empty_lane = LANE_W_MAX'(l);
      end
      if (meta_row[l] == META_DEAD) begin
        res.has_dead  = 1'b1;
        res.dead_lane = LANE_W_MAX'(l);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gthm_ctrl.sv =====
// ----------------------------------------------------------------------------
// gthm_ctrl: probe sequencer
// Runs the clearing pass, steps each request through quadratic group probes
// (lookup, then insert for a set that misses) and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gthm_ctrl #(
  parameter int GROUP_SLOTS = gthm_pkg::DEF_GROUP_SLOTS,
  parameter int MAX_GROUPS  = gthm_pkg::DEF_MAX_GROUPS,
  parameter int VALUE_WIDTH = gthm_pkg::DEF_VALUE_WIDTH,
  parameter int GW          = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [gthm_pkg::HASH_W-1:0] in_key_hash,
  input  logic [gthm_pkg::NODE_W-1:0] in_node_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [gthm_pkg::NODE_W-1:0] out_result_value,
  output logic [1:0]                  out_status,
  input  logic [GW-1:0]               grp_mask,
  input  logic [GW:0]                 grp_count,
  input  gthm_pkg::probe_res_t        probe,
  input  logic [VALUE_WIDTH-1:0]      value_row [GROUP_SLOTS],
  output gthm_pkg::mem_ctl_t          mem_ctl,
  output logic [GW-1:0]               mem_grp,
  output logic [gthm_pkg::HASH_W-1:0] key_hash,
  output logic [VALUE_WIDTH-1:0]      wr_value
);
  import gthm_pkg::*;

  localparam int LW = $clog2(GROUP_SLOTS);
  localparam int CW = GW + 1;

  gthm_state_t state_r, state_nxt;

  logic              cmd_r, cmd_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [NODE_W-1:0] val_r, val_nxt;
  logic              insert_r, insert_nxt;
  logic [GW-1:0]     grp_r, grp_nxt;
  logic [GW-1:0]     sq_r, sq_nxt;
  logic [GW-1:0]     odd_r, odd_nxt;
  logic [CW-1:0]     probe_cnt_r, probe_cnt_nxt;
  logic [GW-1:0]     clr_row_r, clr_row_nxt;
  logic              res_found_r, res_found_nxt;
  logic [NODE_W-1:0] res_value_r, res_value_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [NODE_W-1:0] out_value_r, out_value_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  logic              clr_last;
  logic              out_free;
  logic              lim;
  logic              chk_done;
  logic              chk_restart;
  logic              chk_write;
  logic [LANE_W_MAX-1:0] chk_lane;
  logic              chk_found;
  logic [NODE_W-1:0] chk_value;
  logic [1:0]        chk_status;
  logic [VALUE_WIDTH-1:0] hit_val;
  logic [63:0]       hit_val64;
  logic [63:0]       node64;

  assign clr_last  = (clr_row_r == GW'(MAX_GROUPS - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign lim       = ((probe_cnt_r + CW'(1)) == grp_count);
  assign hit_val   = value_row[probe.hit_lane[LW-1:0]];
  assign hit_val64 = 64'(hit_val);
  assign node64    = 64'(val_r);

  assign key_hash  = hash_r;
  assign wr_value  = node64[VALUE_WIDTH-1:0];

  // Decision on the group row just read.
  always_comb begin
    chk_done    = 1'b0;
    chk_restart = 1'b0;
    chk_write   = 1'b0;
    chk_lane    = probe.empty_lane;
    chk_found   = 1'b0;
    chk_value   = '0;
    chk_status  = STAT_OK;
    if (!insert_r) begin
      if (probe.hit) begin
        chk_done  = 1'b1;
        chk_found = 1'b1;
        if (cmd_r == CMD_SET) begin
          chk_status = STAT_DUP;
        end else begin
          chk_value = hit_val64[NODE_W-1:0];
        end
      end else if (probe.has_empty || lim) begin
        if (cmd_r == CMD_SET) begin
          chk_restart = 1'b1;
        end else begin
          chk_done   = 1'b1;
          chk_status = probe.has_empty ? STAT_NOTFOUND : STAT_FULL;
        end
      end
    end else begin
      if (probe.has_empty || probe.has_dead) begin
        chk_done  = 1'b1;
        chk_write = 1'b1;
        chk_lane  = probe.has_empty ? probe.empty_lane : probe.dead_lane;
      end else if (lim) begin
        chk_done   = 1'b1;
        chk_status = STAT_FULL;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = chk_done ? S_RESULT : S_READ;
      end
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Handshake and memory controls.
  always_comb begin
    in_stall        = 1'b1;
    mem_ctl         = '0;
    mem_grp         = grp_r;
    case (state_r)
      S_CLEAR: begin
        mem_ctl.clr_en = 1'b1;
        mem_grp        = clr_row_r;
      end
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_READ: begin
        mem_ctl.rd_en = 1'b1;
      end
      S_CHECK: begin
        mem_ctl.wr_en   = chk_write;
        mem_ctl.wr_lane = chk_lane;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Request, probe walk and result registers.
  always_comb begin
    cmd_nxt        = cmd_r;
    hash_nxt       = hash_r;
    val_nxt        = val_r;
    insert_nxt     = insert_r;
    grp_nxt        = grp_r;
    sq_nxt         = sq_r;
    odd_nxt        = odd_r;
    probe_cnt_nxt  = probe_cnt_r;
    clr_row_nxt    = clr_row_r;
    res_found_nxt  = res_found_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_found_nxt  = out_found_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    if (state_r == S_CLEAR) begin
      clr_row_nxt = clr_row_r + GW'(1);
    end

    // Latch a new request and aim at its home group.
    if (state_r == S_IDLE && in_valid) begin
      cmd_nxt       = in_cmd;
      hash_nxt      = in_key_hash;
      val_nxt       = in_node_value;
      insert_nxt    = 1'b0;
      grp_nxt       = in_key_hash[GW-1:0] & grp_mask;
      sq_nxt        = GW'(1);
      odd_nxt       = GW'(3);
      probe_cnt_nxt = '0;
    end

    if (state_r == S_CHECK) begin
      if (chk_done) begin
        res_found_nxt  = chk_found;
        res_value_nxt  = chk_value;
        res_status_nxt = chk_status;
      end else if (chk_restart) begin
        // Set that missed: start the insert walk from the home group.
        insert_nxt    = 1'b1;
        grp_nxt       = hash_r[GW-1:0] & grp_mask;
        sq_nxt        = GW'(1);
        odd_nxt       = GW'(3);
        probe_cnt_nxt = '0;
      end else begin
        // Quadratic step: add k*k, kept as a running sum of odd numbers.
        grp_nxt       = (grp_r + sq_r) & grp_mask;
        sq_nxt        = sq_r + odd_r;
        odd_nxt       = odd_r + GW'(2);
        probe_cnt_nxt = probe_cnt_r + CW'(1);
      end
    end

    if (state_r == S_RESULT && out_free) begin
      out_valid_nxt  = 1'b1;
      out_found_nxt  = res_found_r;
      out_value_nxt  = res_value_r;
      out_status_nxt = res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_row_r   <= '0;
      out_valid_r <= 1'b0;
      insert_r    <= 1'b0;
      probe_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      out_valid_r <= out_valid_nxt;
      insert_r    <= insert_nxt;
      probe_cnt_r <= probe_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    hash_r       <= hash_nxt;
    val_r        <= val_nxt;
    grp_r        <= grp_nxt;
    sq_r         <= sq_nxt;
    odd_r        <= odd_nxt;
    res_found_r  <= res_found_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;

  // An accepted request always starts with a row read.
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_READ))
    else $error("accepted request did not start a row read");

  // The probe count never reaches the group count while probing.
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (probe_cnt_r < grp_count))
    else $error("probe count ran past the group count");

  // Slots are written only by the insert walk.
  a_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr_en |-> (insert_r && state_r == S_CHECK))
    else $error("slot write outside the insert walk");

  // No result appears before the clearing pass is over.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result presented during the clearing pass");

  // A result is loaded only after a finished check.
  a_result_after_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT) |-> ($past(state_r) == S_CHECK || $past(state_r) == S_RESULT))
    else $error("result state entered without a completed check");

endmodule

`default_nettype wire

// ===== hdl/grouped_tag_hash_map.sv =====
// ----------------------------------------------------------------------------
// grouped_tag_hash_map: hash map of 64-bit key hashes to node values
// Groups of slots with tag bytes, quadratic group probing, find and set.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the in_ channel (in_valid/in_stall) carries a command (find
//   or set), a 64-bit key hash and a node value. Each request gives exactly
//   one result on the out_ channel (out_valid/out_stall): found flag, stored
//   value on a hit of a find, and a status code.
//   One group probe is a row read and then a row check on the shared
//   lane compare unit. An accepted request goes from the row read and the
//   row check through the result state into the output register, and the
//   block takes the next request once it is back in idle. A set that misses
//   walks the groups twice (lookup then insert), each walk covering at most
//   G groups, G being the group count in use. The block takes one
//   request at a time.
//   After reset the metadata memory is swept to empty, one group row a
//   cycle, over all MAX_GROUPS rows; in_stall stays high meanwhile, while the
//   register port is live throughout.
//   The result sits in an output register; while out_stall holds it there,
//   a finished request waits in the sequencer before taking the register.
//   Write group_count_log2 only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_tag_hash_map #(
  parameter int GROUP_SLOTS = gthm_pkg::DEF_GROUP_SLOTS,
  parameter int MAX_GROUPS  = gthm_pkg::DEF_MAX_GROUPS,
  parameter int VALUE_WIDTH = gthm_pkg::DEF_VALUE_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [gthm_pkg::HASH_W-1:0] in_key_hash,
  input  logic [gthm_pkg::NODE_W-1:0] in_node_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [gthm_pkg::NODE_W-1:0] out_result_value,
  output logic [1:0]                  out_status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gthm_pkg::APB_AW-1:0] paddr,
  input  logic [gthm_pkg::APB_DW-1:0] pwdata,
  output logic [gthm_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import gthm_pkg::*;

  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  logic [GW-1:0]          grp_mask;
  logic [GW:0]            grp_count;
  probe_res_t             probe;
  mem_ctl_t               mem_ctl;
  logic [GW-1:0]          mem_grp;
  logic [HASH_W-1:0]      key_hash;
  logic [VALUE_WIDTH-1:0] wr_value;
  logic [META_W-1:0]      meta_row  [GROUP_SLOTS];
  logic [HASH_W-1:0]      hash_row  [GROUP_SLOTS];
  logic [VALUE_WIDTH-1:0] value_row [GROUP_SLOTS];

  // Configuration register.
  gthm_cfg #(
    .MAX_GROUPS (MAX_GROUPS),
    .GW         (GW)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .grp_mask  (grp_mask),
    .grp_count (grp_count)
  );

  // Slot storage.
  gthm_slot_mem #(
    .GROUP_SLOTS (GROUP_SLOTS),
    .MAX_GROUPS  (MAX_GROUPS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .GW          (GW)
  ) u_mem (
    .clk       (clk),
    .ctl       (mem_ctl),
    .grp       (mem_grp),
    .wr_hash   (key_hash),
    .wr_value  (wr_value),
    .meta_row  (meta_row),
    .hash_row  (hash_row),
    .value_row (value_row)
  );

  // Shared group compare unit.
  gthm_group_probe #(
    .GROUP_SLOTS (GROUP_SLOTS)
  ) u_probe (
    .meta_row (meta_row),
    .hash_row (hash_row),
    .key_hash (key_hash),
    .res      (probe)
  );

  // Probe sequencer and result register.
  gthm_ctrl #(
    .GROUP_SLOTS (GROUP_SLOTS),
    .MAX_GROUPS  (MAX_GROUPS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .GW          (GW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_key_hash      (in_key_hash),
    .in_node_value    (in_node_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .grp_mask         (grp_mask),
    .grp_count        (grp_count),
    .probe            (probe),
    .value_row        (value_row),
    .mem_ctl          (mem_ctl),
    .mem_grp          (mem_grp),
    .key_hash         (key_hash),
    .wr_value         (wr_value)
  );

endmodule

`default_nettype wire
